### hw/rtl/imuifc_pkg.sv
// Shared types, codes and reset constants for the IMU impact and freefall classifier.
// Used by every module of the block; depends on nothing.
package imuifc_pkg;

  // Default number of samples held in the magnitude windows.
  localparam int WINDOW_DEPTH_DEF = 3;

  // Widths fixed by the sample and register formats.
  localparam int AXIS_W  = 16;
  localparam int MAG_W   = 32;
  localparam int SUST_W  = 5;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register reset values.
  localparam logic [MAG_W-1:0]  HEAVY_RST    = 32'd268435456;
  localparam logic [MAG_W-1:0]  MEDIUM_RST   = 32'd67108864;
  localparam logic [MAG_W-1:0]  ROTATION_RST = 32'd96825600;
  localparam logic [MAG_W-1:0]  FREEFALL_RST = 32'd376996;
  localparam logic [SUST_W-1:0] SUST_RST     = 5'd2;

  // Window contents after reset: one g squared for accel, rest for gyro.
  localparam logic [MAG_W-1:0] ACC_WIN_RST  = 32'd4194304;
  localparam logic [MAG_W-1:0] GYRO_WIN_RST = 32'd0;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_HEAVY    = 3'd0;
  localparam logic [2:0] REG_MEDIUM   = 3'd1;
  localparam logic [2:0] REG_ROTATION = 3'd2;
  localparam logic [2:0] REG_FREEFALL = 3'd3;
  localparam logic [2:0] REG_SUST     = 3'd4;

  // Reported event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_HEAVY    = 3'd1,
    EV_MEDIUM   = 3'd2,
    EV_ROTATION = 3'd3,
    EV_FREEFALL = 3'd4
  } event_code_t;

  // Current register settings as seen by the classifier.
  typedef struct packed {
    logic [MAG_W-1:0]  heavy_impact_sq;
    logic [MAG_W-1:0]  medium_impact_sq;
    logic [MAG_W-1:0]  rotation_sq;
    logic [MAG_W-1:0]  freefall_sq;
    logic [SUST_W-1:0] sustained_count;
  } cfg_t;

  // Load enables for the pipeline stages.
  typedef struct packed {
    logic mag_load;
    logic out_load;
  } pipe_ctl_t;

endpackage

### hw/rtl/imuifc_regs.sv
// Configuration register file of the IMU classifier, written over an APB-style port.
// Depends on imuifc_pkg for register indexes, reset values and the cfg_t struct.
module imuifc_regs
  import imuifc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [MAG_W-1:0]  heavy_r, heavy_nxt;
  logic [MAG_W-1:0]  medium_r, medium_nxt;
  logic [MAG_W-1:0]  rotation_r, rotation_nxt;
  logic [MAG_W-1:0]  freefall_r, freefall_nxt;
  logic [SUST_W-1:0] sust_r, sust_nxt;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  // Write decode; indexes past the last register are ignored.
  always_comb begin
    heavy_nxt    = heavy_r;
    medium_nxt   = medium_r;
    rotation_nxt = rotation_r;
    freefall_nxt = freefall_r;
    sust_nxt     = sust_r;
    if (wr_en) begin
      case (reg_idx)
        REG_HEAVY:    heavy_nxt    = pwdata;
        REG_MEDIUM:   medium_nxt   = pwdata;
        REG_ROTATION: rotation_nxt = pwdata;
        REG_FREEFALL: freefall_nxt = pwdata;
        REG_SUST:     sust_nxt     = pwdata[SUST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heavy_r    <= HEAVY_RST;
      medium_r   <= MEDIUM_RST;
      rotation_r <= ROTATION_RST;
      freefall_r <= FREEFALL_RST;
      sust_r     <= SUST_RST;
    end else begin
      heavy_r    <= heavy_nxt;
      medium_r   <= medium_nxt;
      rotation_r <= rotation_nxt;
      freefall_r <= freefall_nxt;
      sust_r     <= sust_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_HEAVY:    prdata = heavy_r;
      REG_MEDIUM:   prdata = medium_r;
      REG_ROTATION: prdata = rotation_r;
      REG_FREEFALL: prdata = freefall_r;
      REG_SUST:     prdata = DATA_W'(sust_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.heavy_impact_sq  = heavy_r;
  assign cfg.medium_impact_sq = medium_r;
  assign cfg.rotation_sq      = rotation_r;
  assign cfg.freefall_sq      = freefall_r;
  assign cfg.sustained_count  = sust_r;

  // A write to the sustained count keeps only its low bits.
  a_sust_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && reg_idx == REG_SUST |=> sust_r == $past(pwdata[SUST_W-1:0]))
    else $error("sustained count write not taken");

endmodule

### hw/rtl/imuifc_mag.sv
// Squared magnitude of one three-axis vector, registered.
// Depends on imuifc_pkg for the axis and magnitude widths.
module imuifc_mag
  import imuifc_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [AXIS_W-1:0] x,
  input  logic signed [AXIS_W-1:0] y,
  input  logic signed [AXIS_W-1:0] z,
  output logic        [MAG_W-1:0]  mag_sq
);

  logic signed [2*AXIS_W-1:0] sq_x, sq_y, sq_z;
  logic        [MAG_W-1:0]    mag_r, mag_nxt;

  // Three squares in parallel; each is at most 2^30, so the sum fits 32 bits.
  assign sq_x    = x * x;
  assign sq_y    = y * y;
  assign sq_z    = z * z;
  assign mag_nxt = MAG_W'($unsigned(sq_x)) + MAG_W'($unsigned(sq_y))
                 + MAG_W'($unsigned(sq_z));

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag_sq = mag_r;

endmodule

### hw/rtl/imuifc_class.sv
// Magnitude windows, per-category counts and the result register of the classifier.
// Depends on imuifc_pkg for cfg_t, pipe_ctl_t, event codes and window reset values.
module imuifc_class
  import imuifc_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pipe_ctl_t        ctl,
  input  cfg_t             cfg,
  input  logic [MAG_W-1:0] acc_new,
  input  logic [MAG_W-1:0] gyro_new,
  output logic [2:0]       event_code,
  output logic [MAG_W-1:0] acc_mag_sq,
  output logic [MAG_W-1:0] gyro_mag_sq
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  logic [MAG_W-1:0]  acc_win_r  [WINDOW_DEPTH];
  logic [MAG_W-1:0]  gyro_win_r [WINDOW_DEPTH];
  logic [MAG_W-1:0]  acc_view   [WINDOW_DEPTH];
  logic [MAG_W-1:0]  gyro_view  [WINDOW_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [WINDOW_DEPTH-1:0] heavy_f, medium_f, rot_f, ff_f;
  logic [CNT_W-1:0]        heavy_cnt, medium_cnt, rot_cnt, ff_cnt;
  event_code_t             code_nxt;
  event_code_t             code_r;
  logic [MAG_W-1:0]        acc_r, gyro_r;

  // Window as it stands once the new sample has replaced the oldest entry.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (slot_r == SLOT_W'(i)) begin
        acc_view[i]  = acc_new;
        gyro_view[i] = gyro_new;
      end else begin
        acc_view[i]  = acc_win_r[i];
        gyro_view[i] = gyro_win_r[i];
      end
    end
  end

  // Per-entry category flags; a heavy sample is never also medium.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      heavy_f[i]  = acc_view[i] >= cfg.heavy_impact_sq;
      medium_f[i] = !heavy_f[i] && (acc_view[i] >= cfg.medium_impact_sq);
      rot_f[i]    = gyro_view[i] >= cfg.rotation_sq;
      ff_f[i]     = acc_view[i] <= cfg.freefall_sq;
    end
  end

  assign heavy_cnt  = CNT_W'($countones(heavy_f));
  assign medium_cnt = CNT_W'($countones(medium_f));
  assign rot_cnt    = CNT_W'($countones(rot_f));
  assign ff_cnt     = CNT_W'($countones(ff_f));

  // Priority pick: heavy, medium, rotation, freefall.
  always_comb begin
    if (SUST_W'(heavy_cnt) >= cfg.sustained_count) begin
      code_nxt = EV_HEAVY;
    end else if (SUST_W'(medium_cnt) >= cfg.sustained_count) begin
      code_nxt = EV_MEDIUM;
    end else if (SUST_W'(rot_cnt) >= cfg.sustained_count) begin
      code_nxt = EV_ROTATION;
    end else if (SUST_W'(ff_cnt) >= cfg.sustained_count) begin
      code_nxt = EV_FREEFALL;
    end else begin
      code_nxt = EV_NONE;
    end
  end

  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  // Window and write slot advance with each word that enters the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        acc_win_r[i]  <= ACC_WIN_RST;
        gyro_win_r[i] <= GYRO_WIN_RST;
      end
    end else if (ctl.out_load) begin
      slot_r <= slot_nxt;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        acc_win_r[i]  <= acc_view[i];
        gyro_win_r[i] <= gyro_view[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      code_r <= code_nxt;
      acc_r  <= acc_new;
      gyro_r <= gyro_new;
    end
  end

  assign event_code  = code_r;
  assign acc_mag_sq  = acc_r;
  assign gyro_mag_sq = gyro_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("write slot out of window range");

  a_sust_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load && cfg.sustained_count == '0 |=> code_r == EV_HEAVY)
    else $error("zero sustained count must report heavy impact");

  a_sust_big: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load && cfg.sustained_count > SUST_W'(WINDOW_DEPTH) |=> code_r == EV_NONE)
    else $error("unreachable sustained count must report none");

endmodule

### hw/rtl/imu_impact_freefall_classifier_core.sv
// Top level of the IMU impact and freefall classifier: handshake control and stage wiring.
// Depends on imuifc_pkg, imuifc_regs, imuifc_mag and imuifc_class.
//
// Usage: each input word is one raw IMU sample (three accel and three gyro axes,
// signed 16-bit counts) on the in_ channel; each result word carries the event code
// and both squared magnitudes on the out_ channel. A word moves when valid is high
// and stall is low. Thresholds and the sustained count sit behind the APB-style port
// (register i at byte address 4*i); the user must write them only while the block is idle,
// which the block itself does not enforce. The input register loads at the accept edge,
// then the magnitude register (three 16x16 squares and their sum) and then the result
// register (window compare over WINDOW_DEPTH entries, counts and priority pick) load in
// turn. Throughput is one word per cycle while out_stall is low; a new input word can be
// accepted while earlier words are still in the later stages.
// When out_stall is held, the three stages fill one after another and in_stall
// rises only once all three hold words; a stalled result holds its value.
// Reset clears all valid bits, loads the register defaults and fills the accel
// window with one g squared and the gyro window with zero in the same cycle.
module imu_impact_freefall_classifier_core
  import imuifc_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [AXIS_W-1:0] in_acc_x,
  input  logic signed [AXIS_W-1:0] in_acc_y,
  input  logic signed [AXIS_W-1:0] in_acc_z,
  input  logic signed [AXIS_W-1:0] in_gyro_x,
  input  logic signed [AXIS_W-1:0] in_gyro_y,
  input  logic signed [AXIS_W-1:0] in_gyro_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_event_code,
  output logic [MAG_W-1:0]         out_acc_mag_sq,
  output logic [MAG_W-1:0]         out_gyro_mag_sq,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  cfg_t      cfg;
  pipe_ctl_t ctl;

  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_ok, s2_ok, s1_ok;

  logic signed [AXIS_W-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [AXIS_W-1:0] gyro_x_r, gyro_y_r, gyro_z_r;
  logic        [MAG_W-1:0]  acc_mag, gyro_mag;

  // A stage may load when it is empty or its word moves on this cycle.
  assign out_ok = !out_valid_r || !out_stall;
  assign s2_ok  = !s2_valid_r || out_ok;
  assign s1_ok  = !s1_valid_r || s2_ok;

  assign in_stall     = !s1_ok;
  assign ctl.mag_load = s2_ok && s1_valid_r;
  assign ctl.out_load = out_ok && s2_valid_r;

  assign s1_valid_nxt  = s1_ok  ? in_valid   : s1_valid_r;
  assign s2_valid_nxt  = s2_ok  ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = out_ok ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (s1_ok && in_valid) begin
      acc_x_r  <= in_acc_x;
      acc_y_r  <= in_acc_y;
      acc_z_r  <= in_acc_z;
      gyro_x_r <= in_gyro_x;
      gyro_y_r <= in_gyro_y;
      gyro_z_r <= in_gyro_z;
    end
  end

  imuifc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imuifc_mag u_acc_mag (
    .clk    (clk),
    .load   (ctl.mag_load),
    .x      (acc_x_r),
    .y      (acc_y_r),
    .z      (acc_z_r),
    .mag_sq (acc_mag)
  );

  imuifc_mag u_gyro_mag (
    .clk    (clk),
    .load   (ctl.mag_load),
    .x      (gyro_x_r),
    .y      (gyro_y_r),
    .z      (gyro_z_r),
    .mag_sq (gyro_mag)
  );

  imuifc_class #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_class (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .cfg         (cfg),
    .acc_new     (acc_mag),
    .gyro_new    (gyro_mag),
    .event_code  (out_event_code),
    .acc_mag_sq  (out_acc_mag_sq),
    .gyro_mag_sq (out_gyro_mag_sq)
  );

  assign out_valid = out_valid_r;

  // The input side stalls only when every stage holds a word and the output is stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r && out_valid_r && out_stall)
    else $error("input stalled while the pipeline has room");

endmodule
